// ===== hw/rtl/rkf_pkg.sv =====
// Package for the run-length kth symbol finder.
// Holds widths, byte codes, status codes and the structs passed between the
// front parser, the command queue and the back unit. No dependencies.
package rkf_pkg;

  // Largest number of letters buffered for one group.
  localparam int MAX_GROUP = 64;

  localparam int CHAR_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 48;
  localparam int COUNT_W   = 32;
  localparam int GRP_IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int GRP_LEN_W = $clog2(MAX_GROUP + 1);
  localparam int SPAN_W    = COUNT_W + GRP_LEN_W;
  localparam int CNT_EXT_W = COUNT_W + 4;
  localparam int DIV_CNT_W = $clog2(POS_W);

  // Two letter banks, so the parser fills one while the back unit reads the other.
  localparam int NUM_BANKS = 2;
  localparam int RAM_DEPTH = NUM_BANKS * MAX_GROUP;
  localparam int RAM_AW    = GRP_IDX_W + 1;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Byte codes of the encoded stream.
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;

  localparam logic [3:0] DECIMAL_BASE_SHIFT_HI = 4'd3;
  localparam logic [3:0] DECIMAL_BASE_SHIFT_LO = 4'd1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND  = 2'd0,
    ST_BEYOND = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  // One closed group, as handed from the parser to the back unit.
  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [GRP_LEN_W-1:0] len;
    logic                 bank;
    logic                 last;
    logic                 err;
  } grp_cmd_t;

  // Back unit tells the parser that a letter bank is free again.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Letter write into the group buffer.
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [CHAR_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== hw/rtl/rkf_ifs.sv =====
// Valid/ready channel interfaces for the run-length kth symbol finder.
// Depends on rkf_pkg for field widths.
interface rkf_in_if;
  import rkf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface rkf_out_if;
  import rkf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   found_char;
  logic [STATUS_W-1:0] status;

  modport source (output valid, found_char, status, input ready);
  modport sink   (input valid, found_char, status, output ready);
endinterface

// ===== hw/rtl/rle_group_kth_symbol_finder.sv =====
// Top level of the run-length kth symbol finder; depends on rkf_pkg, rkf_ifs, rkf_ram,
// rkf_front, rkf_cmd_fifo and rkf_back.
// Throughput: one byte per cycle while a letter bank is free and the queue has room; the back
// unit handles each closed group in S_MUL and S_CMP, plus S_MOD (bit-serial modulo), S_RD
// and S_CAPT when it picks the letter; the result leaves S_EMIT once earlier groups drain.
// Reset (synchronous, rst_n low) clears the parser, queue and sequencer; the target is 1.
module rle_group_kth_symbol_finder (
  input  logic                      clk,
  input  logic                      rst_n,
  rkf_in_if.sink                    in_chan,
  rkf_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [rkf_pkg::POS_W-1:0] cfg_wdata
);
  import rkf_pkg::*;

  logic              q_push;
  grp_cmd_t          q_cmd;
  logic              q_full;
  logic              q_empty;
  grp_cmd_t          q_head;
  logic              q_pop;
  bank_rel_t         rel;
  ram_wr_t           ram_wr;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;

  // Byte parser.
  rkf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .q_push (q_push),
    .q_cmd  (q_cmd),
    .q_full (q_full),
    .rel    (rel),
    .ram_wr (ram_wr)
  );

  // Closed groups waiting for the back unit.
  rkf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Two banks of group letters.
  rkf_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(RAM_DEPTH)
  ) u_letters (
    .clk    (clk),
    .wr_en  (ram_wr.en),
    .wr_addr(ram_wr.addr),
    .wr_data(ram_wr.data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Position arithmetic and result delivery.
  rkf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .rel      (rel),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_chan (out_chan)
  );

endmodule

// ===== hw/rtl/rkf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rkf_front.sv =====
// Front parser of the run-length kth symbol finder: accepts bytes, buffers
// letters, accumulates the repeat count and queues each closed group.
// Depends on rkf_pkg and rkf_ifs.
module rkf_front (
  input  logic               clk,
  input  logic               rst_n,
  rkf_in_if.sink             in_chan,
  output logic               q_push,
  output rkf_pkg::grp_cmd_t  q_cmd,
  input  logic               q_full,
  input  rkf_pkg::bank_rel_t rel,
  output rkf_pkg::ram_wr_t   ram_wr
);
  import rkf_pkg::*;

  logic                 in_digit_r, in_digit_nxt;
  logic [GRP_LEN_W-1:0] len_r, len_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 bank_r, bank_nxt;
  logic                 err_r, err_nxt;
  logic [NUM_BANKS-1:0] busy_r, busy_nxt;

  logic                 accept;
  logic                 is_letter;
  logic                 is_digit;
  logic                 close_old;
  logic [CHAR_W-1:0]    digit_byte;
  logic [CNT_EXT_W-1:0] count_ext;
  logic [CNT_EXT_W-1:0] count_acc;

  // Take a byte only when the queue has room and the bank it may write is free.
  assign in_chan.ready = !q_full && !busy_r[bank_r] && !(in_digit_r && busy_r[~bank_r]);
  assign accept        = in_chan.valid && in_chan.ready;

  // Byte classes and the saturating decimal accumulate.
  assign is_letter  = (in_chan.char_code >= CH_LOWER_A) && (in_chan.char_code <= CH_LOWER_Z);
  assign is_digit   = (in_chan.char_code >= CH_DIGIT_0) && (in_chan.char_code <= CH_DIGIT_9);
  assign digit_byte = in_chan.char_code - CH_DIGIT_0;
  assign count_ext  = CNT_EXT_W'(count_r);
  assign count_acc  = (count_ext << DECIMAL_BASE_SHIFT_HI) + (count_ext << DECIMAL_BASE_SHIFT_LO)
                    + CNT_EXT_W'(digit_byte[3:0]);

  // A letter after a digit closes the group being parsed.
  assign close_old = accept && is_letter && in_digit_r;

  // Parser next state.
  always_comb begin
    in_digit_nxt = in_digit_r;
    len_nxt      = len_r;
    count_nxt    = count_r;
    bank_nxt     = bank_r;
    err_nxt      = err_r;
    ram_wr       = '0;
    ram_wr.data  = in_chan.char_code;
    if (accept) begin
      priority if (is_letter) begin
        if (in_digit_r) begin
          // New group starts in the other bank.
          ram_wr.en    = 1'b1;
          ram_wr.addr  = {~bank_r, GRP_IDX_W'(0)};
          len_nxt      = GRP_LEN_W'(1);
          count_nxt    = '0;
          in_digit_nxt = 1'b0;
          bank_nxt     = ~bank_r;
        end else if (len_r < GRP_LEN_W'(MAX_GROUP)) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = {bank_r, len_r[GRP_IDX_W-1:0]};
          len_nxt     = len_r + GRP_LEN_W'(1);
        end else begin
          err_nxt = 1'b1;
        end
      end else if (is_digit) begin
        in_digit_nxt = 1'b1;
        if (count_acc[CNT_EXT_W-1:COUNT_W] != '0) begin
          count_nxt = '1;
        end else begin
          count_nxt = count_acc[COUNT_W-1:0];
        end
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  // Queue a group on a close, and always on the last byte of the string.
  assign q_push      = close_old || (accept && in_chan.last_char);
  assign q_cmd.count = close_old ? count_r : count_nxt;
  assign q_cmd.len   = close_old ? len_r : len_nxt;
  assign q_cmd.bank  = bank_r;
  assign q_cmd.last  = in_chan.last_char;
  assign q_cmd.err   = err_nxt;

  // Bank busy flags: set when a group is queued, cleared when the back is done.
  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (q_push) begin
      busy_nxt[q_cmd.bank] = 1'b1;
    end
  end

  // Parser registers; the end of a string restarts in the other bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_digit_r <= 1'b0;
      len_r      <= '0;
      count_r    <= '0;
      bank_r     <= 1'b0;
      err_r      <= 1'b0;
      busy_r     <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (accept && in_chan.last_char) begin
        in_digit_r <= 1'b0;
        len_r      <= '0;
        count_r    <= '0;
        bank_r     <= ~bank_r;
        err_r      <= 1'b0;
      end else begin
        in_digit_r <= in_digit_nxt;
        len_r      <= len_nxt;
        count_r    <= count_nxt;
        bank_r     <= bank_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  // A group is never queued into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("group queued while the queue is full");

  // Letters never land in a bank the back unit still reads.
  a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |-> !busy_r[ram_wr.addr[RAM_AW-1]])
    else $error("letter written into a busy bank");

  // The group length never passes the buffer size.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= GRP_LEN_W'(MAX_GROUP))
    else $error("group length beyond buffer size");

endmodule

// ===== hw/rtl/rkf_cmd_fifo.sv =====
// Short queue of closed groups between the front parser and the back unit.
// Depends on rkf_pkg.
module rkf_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rkf_pkg::grp_cmd_t push_data,
  input  logic              pop,
  output rkf_pkg::grp_cmd_t head,
  output logic              full,
  output logic              empty
);
  import rkf_pkg::*;

  grp_cmd_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Entry storage, no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rkf_back.sv =====
// Back unit of the run-length kth symbol finder: for each closed group it
// multiplies, compares and subtracts, or picks a letter through a bit-serial
// modulo, and delivers the result item. Depends on rkf_pkg and rkf_ifs.
module rkf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  rkf_pkg::grp_cmd_t            q_head,
  output logic                         q_pop,
  output rkf_pkg::bank_rel_t           rel,
  output logic                         rd_en,
  output logic [rkf_pkg::RAM_AW-1:0]   rd_addr,
  input  logic [rkf_pkg::CHAR_W-1:0]   rd_data,
  input  logic                         cfg_we,
  input  logic [rkf_pkg::POS_W-1:0]    cfg_wdata,
  rkf_out_if.source                    out_chan
);
  import rkf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_MOD,
    S_RD,
    S_CAPT,
    S_EMIT
  } state_t;

  state_t               state_r;
  grp_cmd_t             cmd_r;
  logic [SPAN_W-1:0]    span_r;
  logic [POS_W-1:0]     target_r;
  logic [POS_W-1:0]     rem_r;
  logic [POS_W-1:0]     div_r;
  logic [GRP_IDX_W-1:0] acc_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 ans_found_r;
  logic [CHAR_W-1:0]    ans_char_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  status_t              out_status_r;

  logic                 skip;
  logic                 beyond;
  logic [GRP_IDX_W:0]   trial;
  logic [GRP_IDX_W:0]   len_ext;
  logic                 out_free;
  logic                 emit_now;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.found_char = out_char_r;
  assign out_chan.status     = out_status_r;
  assign out_free            = !out_valid_r || out_chan.ready;
  assign emit_now            = (state_r == S_EMIT) && out_free;

  // Group decision: skip, subtract the span, or pick a letter inside it.
  assign skip   = ans_found_r || (rem_r == '0) || (cmd_r.len == '0);
  assign beyond = rem_r > POS_W'(span_r);

  // One restoring step of the remainder by the group length.
  assign trial   = {acc_r, div_r[POS_W-1]};
  assign len_ext = (GRP_IDX_W + 1)'(cmd_r.len);

  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign rd_en   = (state_r == S_RD);
  assign rd_addr = {cmd_r.bank, acc_r};

  // The bank is released once the group is fully handled.
  assign rel.valid = ((state_r == S_CMP) && (skip || beyond)) || (state_r == S_CAPT);
  assign rel.bank  = cmd_r.bank;

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= POS_W'(1);
      rem_r        <= POS_W'(1);
      ans_found_r  <= 1'b0;
      ans_char_r   <= '0;
      out_valid_r  <= 1'b0;
      out_char_r   <= '0;
      out_status_r <= ST_FOUND;
      cnt_r        <= '0;
    end else begin
      // The result register is loaded by the emit step and cleared once taken.
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // A register write reloads the remaining position at once.
      if (cfg_we) begin
        target_r <= cfg_wdata;
        rem_r    <= cfg_wdata;
      end else if ((state_r == S_CMP) && !skip && beyond) begin
        rem_r <= rem_r - POS_W'(span_r);
      end else if (emit_now) begin
        rem_r <= target_r;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_head;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          span_r  <= SPAN_W'(cmd_r.count) * SPAN_W'(cmd_r.len);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (skip) begin
            state_r <= cmd_r.last ? S_EMIT : S_IDLE;
          end else if (beyond) begin
            state_r <= cmd_r.last ? S_EMIT : S_IDLE;
          end else begin
            div_r   <= rem_r - POS_W'(1);
            acc_r   <= '0;
            cnt_r   <= DIV_CNT_W'(POS_W - 1);
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (trial >= len_ext) begin
            acc_r <= GRP_IDX_W'(trial - len_ext);
          end else begin
            acc_r <= GRP_IDX_W'(trial);
          end
          div_r <= div_r << 1;
          cnt_r <= cnt_r - DIV_CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CAPT;
        end
        S_CAPT: begin
          ans_char_r  <= rd_data;
          ans_found_r <= 1'b1;
          state_r     <= cmd_r.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            priority if (cmd_r.err) begin
              out_status_r <= ST_ERROR;
              out_char_r   <= '0;
            end else if (ans_found_r) begin
              out_status_r <= ST_FOUND;
              out_char_r   <= ans_char_r;
            end else begin
              out_status_r <= ST_BEYOND;
              out_char_r   <= '0;
            end
            ans_found_r <= 1'b0;
            ans_char_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The picked index always lies inside the group.
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (len_ext > {1'b0, acc_r}))
    else $error("letter index outside the group");

  // A result appears only from the emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside the emit step");

  // Only the final group of a string leads to a result.
  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> cmd_r.last)
    else $error("result step for a group that is not last");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for rle_group_kth_symbol_finder: feeds encoded run-length strings
// item by item and checks each result against a scoreboard with its own decoder.
// Depends on rkf_pkg, the rkf_ifs channel interfaces and the RTL top level.
module tb_top;
  import rkf_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 64;
  localparam int DRAIN_LIMIT    = 40000;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int RANDOM_BYTES   = 1300;

  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [63:0]      COUNT_SAT   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0]      DECIMAL_RADIX = 64'd10;

  // One expected or observed result item.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    status_t           st;
  } kth_answer_t;

  // Scoreboard: decodes the byte stream and queues the answer each string gives.
  class kth_scoreboard;
    logic [CHAR_W-1:0] letters [MAX_GROUP];
    int                grp_len;
    logic [63:0]       count;
    logic [POS_W-1:0]  target;
    logic [POS_W-1:0]  remaining;
    bit                digit_phase;
    bit                ans_found;
    bit                err_seen;
    logic [CHAR_W-1:0] ans_char;
    kth_answer_t       awaited [$];
    int                n_errors;
    int                n_checked;
    int                n_found;
    int                n_beyond;
    int                n_bad;
    int                n_strings;
    int                n_settings;

    function new();
      target = POS_W'(1);
      restart();
    endfunction

    function void restart();
      grp_len     = 0;
      count       = '0;
      remaining   = target;
      digit_phase = 1'b0;
      ans_char    = '0;
      ans_found   = 1'b0;
      err_seen    = 1'b0;
    endfunction

    function void set_target(logic [POS_W-1:0] value);
      target    = value;
      remaining = value;
      n_settings++;
    endfunction

    task report(string msg);
      n_errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function int pending();
      return awaited.size();
    endfunction

    // A group closes: either skip its whole span or pick the wanted letter.
    function void settle_group();
      logic [63:0] span;
      logic [63:0] offset;
      if (!ans_found && remaining != '0 && grp_len != 0) begin
        span = count * 64'(grp_len);
        if (64'(remaining) > span) begin
          remaining = remaining - span[POS_W-1:0];
        end else begin
          offset    = (64'(remaining) - 64'd1) % 64'(grp_len);
          ans_char  = letters[int'(offset)];
          ans_found = 1'b1;
        end
      end
      grp_len     = 0;
      count       = '0;
      digit_phase = 1'b0;
    endfunction

    // Accepted input item: parse the byte and, on the last one, queue the answer.
    function void note_byte(logic [CHAR_W-1:0] c, logic lst);
      logic [63:0] grown;
      kth_answer_t ans;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        if (digit_phase) settle_group();
        if (grp_len < MAX_GROUP) begin
          letters[grp_len] = c;
          grp_len++;
        end else begin
          err_seen = 1'b1;
        end
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
        digit_phase = 1'b1;
        grown = count * DECIMAL_RADIX + 64'(c - CH_DIGIT_0);
        count = (grown > COUNT_SAT) ? COUNT_SAT : grown;
      end else begin
        err_seen = 1'b1;
      end
      if (lst) begin
        settle_group();
        if (err_seen) begin
          ans.ch = '0;
          ans.st = ST_ERROR;
          n_bad++;
        end else if (ans_found) begin
          ans.ch = ans_char;
          ans.st = ST_FOUND;
          n_found++;
        end else begin
          ans.ch = '0;
          ans.st = ST_BEYOND;
          n_beyond++;
        end
        awaited.insert(awaited.size(), ans);
        n_strings++;
        restart();
      end
    endfunction

    // Accepted result item: compare with the oldest expected answer.
    task check_result(logic [CHAR_W-1:0] ch, logic [STATUS_W-1:0] st);
      kth_answer_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing expected: char %h status %0d", ch, st));
        return;
      end
      exp = awaited.pop_front();
      n_checked++;
      if (st !== exp.st)
        report($sformatf("status %0d, expected %s", st, exp.st.name()));
      if (ch !== exp.ch)
        report($sformatf("found_char %h, expected %h", ch, exp.ch));
    endtask

    task flush_leftovers();
      while (awaited.size() != 0) begin
        report($sformatf("expected result never arrived: status %s",
                         awaited[0].st.name()));
        void'(awaited.pop_front());
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [POS_W-1:0]  cfg_wdata;
  int                src_idle_pct;
  int                snk_idle_pct;
  int                random_bytes;
  logic [CHAR_W-1:0] text_q [$];
  kth_scoreboard     sb = new();

  rkf_in_if  in_if ();
  rkf_out_if out_if ();

  rle_group_kth_symbol_finder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Sample both channels at the rising edge; inputs are noted before results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.char_code, in_if.last_char);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.found_char, out_if.status);
    end
  end

  // Result receiver: stalls at random at the current idle rate.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = (int'($urandom_range(99)) >= snk_idle_pct) && rst_n;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  // Send one item, with random idle cycles in front of it.
  task automatic send_byte(input logic [CHAR_W-1:0] b, input logic lst);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.char_code = b;
    in_if.last_char = lst;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Append one byte to the string being built.
  task automatic append_byte(input logic [CHAR_W-1:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(CHAR_W'(s[i]));
  endtask

  // Send the queued string, marking its final byte as last.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic write_target(input logic [POS_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_target(value);
  endtask

  // Wait for every expected result, then let the back unit go quiet.
  task automatic drain_results();
    int waited;
    waited      = 0;
    in_if.valid = 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (sb.pending() != 0) sb.report("results still outstanding after drain limit");
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_target();
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 2) return '0;
    if (pick < 12) return POS_W'(1);
    if (pick < 17) return POS_MAX;
    if (pick < 25) return {16'($urandom), 32'($urandom)};
    if (pick < 65) return POS_W'($urandom_range(1, 30));
    return POS_W'($urandom_range(1, 400));
  endfunction

  // Build a random string: mostly well-formed groups, some broken or noisy ones.
  task automatic build_random_text();
    int n_groups;
    int n_letters;
    int n_digits;
    int pick;
    int n_noise;
    n_groups = int'($urandom_range(1, 4));
    // Occasionally a count with no letters in front of it.
    if ($urandom_range(99) < 5) append_byte(CH_DIGIT_0 + CHAR_W'($urandom_range(9)));
    for (int g = 0; g < n_groups; g++) begin
      pick      = int'($urandom_range(99));
      n_letters = (pick < 4) ? int'($urandom_range(60, 70)) : int'($urandom_range(1, 6));
      repeat (n_letters) append_byte(CH_LOWER_A + CHAR_W'($urandom_range(25)));
      // A final group may be left without a count.
      if (g != n_groups - 1 || $urandom_range(99) >= 10) begin
        pick     = int'($urandom_range(99));
        n_digits = (pick < 70) ? 1 : (pick < 88) ? 2 : (pick < 94) ? 3
                                   : int'($urandom_range(10, 12));
        repeat (n_digits) append_byte(CH_DIGIT_0 + CHAR_W'($urandom_range(9)));
      end
    end
    // Noise: arbitrary bytes dropped in at random places.
    if ($urandom_range(99) < 8) begin
      n_noise = int'($urandom_range(1, 2));
      repeat (n_noise)
        text_q.insert(int'($urandom_range(text_q.size())), CHAR_W'($urandom_range(255)));
    end
    random_bytes += text_q.size();
  endtask

  // Main sequence: reset, directed strings, then three idling phases.
  initial begin
    int phase_end;
    int n_str;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.last_char = 1'b0;
    src_idle_pct    = 7;
    snk_idle_pct    = 80;
    random_bytes    = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Letters without a count, then the simplest hit.
    write_target(POS_W'(1));
    push_str("a");
    send_text();
    push_str("a1");
    send_text();
    drain_results();
    // Position zero never matches.
    write_target('0);
    push_str("b2");
    send_text();
    drain_results();
    // Count without letters ahead of a group, hit inside a repeat.
    write_target(POS_W'(3));
    push_str("5ab2");
    send_text();
    drain_results();
    // Saturating count, widest target.
    write_target(POS_MAX);
    push_str("z99999999999");
    send_text();
    drain_results();
    // Bad bytes at both byte extremes; the error wins over the found letter.
    write_target(POS_W'(1));
    append_byte(8'h00);
    push_str("y1");
    append_byte(8'hFF);
    send_text();
    drain_results();

    // Random strings under three idling patterns.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 80 : 0;
      snk_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 7 : 0;
      phase_end    = (RANDOM_BYTES * (phase + 1)) / 3;
      while (random_bytes < phase_end) begin
        write_target(pick_target());
        n_str = int'($urandom_range(3, 8));
        repeat (n_str) begin
          build_random_text();
          send_text();
        end
        drain_results();
      end
    end

    sb.flush_leftovers();
    $display("Covered %0d strings (%0d random bytes) over %0d target settings;",
             sb.n_strings, random_bytes, sb.n_settings);
    $display("results checked: %0d, found %0d, beyond %0d, error %0d",
             sb.n_checked, sb.n_found, sb.n_beyond, sb.n_bad);
    if (sb.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
